FILE: hw/rtl/lst_pkg.sv
// Shared constants, codes and types of the light slot table.
`default_nettype none

package lst_pkg;

	// Table geometry
	localparam int LIGHT_SLOTS = 32;
	localparam int SLOT_W      = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;

	// Field widths
	localparam int KEY_W      = 16;
	localparam int TIME_W     = 32;
	localparam int ELAPSED_W  = 16;
	localparam int RADIUS_W   = 20;
	localparam int IDX_W      = 5;
	localparam int PROD_W     = ELAPSED_W + RADIUS_W;
	localparam int LOSS_SHIFT = 10;
	localparam int LOSS_W     = PROD_W - LOSS_SHIFT;

	// Command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [1:0] {
		HOW_KEY     = 2'd0,
		HOW_EXPIRED = 2'd1,
		HOW_EVICT   = 2'd2,
		HOW_TICK    = 2'd3
	} found_how_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [TIME_W-1:0]   expiry;
		logic [RADIUS_W-1:0] radius;
		logic [RADIUS_W-1:0] decay;
	} slot_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_entry_t       entry;
	} slot_wr_t;

	typedef struct packed {
		logic              vld;
		logic              key_hit;
		logic              expired;
		logic [SLOT_W-1:0] addr;
	} scan_hit_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lst_slot_mem.sv
// Slot storage: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module lst_slot_mem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lst_pkg::slot_wr_t         wr,
	input  wire logic                      rd_en,
	input  wire logic [lst_pkg::SLOT_W-1:0] rd_addr,
	output lst_pkg::slot_entry_t           rd_data
);

	lst_pkg::slot_entry_t             mem_q [lst_pkg::LIGHT_SLOTS];
	logic [lst_pkg::LIGHT_SLOTS-1:0]  valid_q;
	lst_pkg::slot_entry_t             rd_data_q;
	logic                             rd_valid_q;

	// Write entry data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.entry;
		end
	end

	// Mark written entries valid; reset empties the table at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= mem_q[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// Never-written entries read as zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/lst_slot_unit.sv
// Shared per-slot unit: key and expiry compare, then decay multiply and clamp.
`default_nettype none

module lst_slot_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [lst_pkg::SLOT_W-1:0]   rd_addr,
	input  wire lst_pkg::slot_entry_t         entry,
	input  wire logic                         cmd,
	input  wire logic [lst_pkg::KEY_W-1:0]    key,
	input  wire logic [lst_pkg::TIME_W-1:0]   now,
	input  wire logic [lst_pkg::ELAPSED_W-1:0] elapsed,
	output lst_pkg::scan_hit_t                hit,
	output lst_pkg::slot_wr_t                 wr
);

	logic                          v_s1;
	logic [lst_pkg::SLOT_W-1:0]    addr_s1;
	logic                          expired;
	logic                          v_s2;
	logic [lst_pkg::SLOT_W-1:0]    addr_s2;
	lst_pkg::slot_entry_t          entry_s2;
	logic [lst_pkg::PROD_W-1:0]    prod_s2;
	logic [lst_pkg::LOSS_W-1:0]    loss;
	logic [lst_pkg::RADIUS_W-1:0]  new_radius;

	// Track which slot the memory output belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

	// Compare stage
	assign expired     = entry.expiry < now;
	assign hit.vld     = v_s1 && (cmd == lst_pkg::CMD_ALLOC);
	assign hit.key_hit = (key != '0) && (entry.key == key);
	assign hit.expired = expired;
	assign hit.addr    = addr_s1;

	// Multiply stage: only live slots with radius left are written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && (cmd == lst_pkg::CMD_TICK) && !expired && (entry.radius != '0);
		end
	end

	always_ff @(posedge clk) begin
		addr_s2  <= addr_s1;
		entry_s2 <= entry;
		prod_s2  <= lst_pkg::PROD_W'(elapsed) * lst_pkg::PROD_W'(entry.decay);
	end

	// Clamp stage
	assign loss       = prod_s2[lst_pkg::PROD_W-1:lst_pkg::LOSS_SHIFT];
	assign new_radius = (loss >= lst_pkg::LOSS_W'(entry_s2.radius)) ? '0
		: entry_s2.radius - loss[lst_pkg::RADIUS_W-1:0];

	assign wr.en           = v_s2;
	assign wr.addr         = addr_s2;
	assign wr.entry.key    = entry_s2.key;
	assign wr.entry.expiry = entry_s2.expiry;
	assign wr.entry.radius = new_radius;
	assign wr.entry.decay  = entry_s2.decay;

endmodule

`default_nettype wire

FILE: hw/rtl/light_slot_table_core.sv
// Top level of the light slot table: sequencer, input capture and result register.
//
// channel  dir  tdata (low bit up)                                       tuser
// s_*      in   light_key, now_time, elapsed_time, expiry_time,           command
//               start_radius, decay_rate (136 bits)
// m_*      out  slot_index (5 bits, padded to 8)                          found_how
//
// From transfer to result an item passes the scan, drain, write and done states:
// scan reads each slot in turn through the single read port of the slot memory,
// drain empties the read and multiply stages, write stores an allocated slot and
// done loads a free result register, then returns to idle for the next transfer.
// Reset clears the slot valid bits at once; no clearing pass follows it.
// A result waits in the output register while the next item is taken in; that item
// holds in its final state until the waiting result has been transferred.
`default_nettype none

module light_slot_table_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// light_key, now_time, elapsed_time, expiry_time, start_radius, decay_rate
	input  wire logic [135:0] s_tdata,
	// command
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// slot_index, zero pad
	output logic [7:0]        m_tdata,
	// found_how
	output logic [1:0]        m_tuser
);

	localparam int CHOSEN_EXT_W = lst_pkg::SLOT_W + lst_pkg::IDX_W;

	lst_pkg::seq_state_t             state_q, state_d;
	logic [lst_pkg::SLOT_W-1:0]      cnt_q;
	logic                            drain_q;
	logic                            cmd_q;
	logic [lst_pkg::KEY_W-1:0]       key_q;
	logic [lst_pkg::TIME_W-1:0]      now_q;
	logic [lst_pkg::ELAPSED_W-1:0]   elapsed_q;
	lst_pkg::slot_entry_t            new_entry_q;
	logic                            key_found_q, exp_found_q;
	logic [lst_pkg::SLOT_W-1:0]      key_addr_q, exp_addr_q;
	logic                            out_vld_q;
	logic [lst_pkg::IDX_W-1:0]       out_idx_q;
	lst_pkg::found_how_t             out_how_q;

	logic                            accept;
	logic                            scan_last;
	logic                            rd_en;
	logic                            alloc_wr;
	logic                            load_out;
	logic [lst_pkg::SLOT_W-1:0]      chosen;
	lst_pkg::found_how_t             chosen_how;
	logic [CHOSEN_EXT_W-1:0]         chosen_ext;
	lst_pkg::slot_entry_t            rd_data;
	lst_pkg::scan_hit_t              hit;
	lst_pkg::slot_wr_t               unit_wr, mem_wr;

	assign accept    = s_tvalid && s_tready;
	assign scan_last = cnt_q == lst_pkg::SLOT_W'(lst_pkg::LIGHT_SLOTS - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lst_pkg::ST_IDLE:  if (s_tvalid) state_d = lst_pkg::ST_SCAN;
			lst_pkg::ST_SCAN:  if (scan_last) state_d = lst_pkg::ST_DRAIN;
			lst_pkg::ST_DRAIN: if (drain_q) state_d = lst_pkg::ST_WRITE;
			lst_pkg::ST_WRITE: state_d = lst_pkg::ST_DONE;
			lst_pkg::ST_DONE:  if (!out_vld_q || m_tready) state_d = lst_pkg::ST_IDLE;
			default:           state_d = lst_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		alloc_wr = 1'b0;
		load_out = 1'b0;
		case (state_q)
			lst_pkg::ST_IDLE:  s_tready = 1'b1;
			lst_pkg::ST_SCAN:  rd_en = 1'b1;
			lst_pkg::ST_WRITE: alloc_wr = cmd_q == lst_pkg::CMD_ALLOC;
			lst_pkg::ST_DONE:  load_out = !out_vld_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// State, scan counter and drain flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lst_pkg::ST_IDLE;
			cnt_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en && !scan_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			drain_q <= (state_q == lst_pkg::ST_DRAIN) && !drain_q;
		end
	end

	// Capture the item on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q              <= s_tuser;
			key_q              <= s_tdata[15:0];
			now_q              <= s_tdata[47:16];
			elapsed_q          <= s_tdata[63:48];
			new_entry_q.key    <= s_tdata[15:0];
			new_entry_q.expiry <= s_tdata[95:64];
			new_entry_q.radius <= s_tdata[115:96];
			new_entry_q.decay  <= s_tdata[135:116];
		end
	end

	// Record the first key match and the first expired slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_found_q <= 1'b0;
			exp_found_q <= 1'b0;
		end else if (accept) begin
			key_found_q <= 1'b0;
			exp_found_q <= 1'b0;
		end else if (hit.vld) begin
			if (hit.key_hit && !key_found_q) begin
				key_found_q <= 1'b1;
			end
			if (hit.expired && !exp_found_q) begin
				exp_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit.vld && hit.key_hit && !key_found_q) begin
			key_addr_q <= hit.addr;
		end
		if (hit.vld && hit.expired && !exp_found_q) begin
			exp_addr_q <= hit.addr;
		end
	end

	// Pick the slot: key match, then expired, then evict slot 0
	always_comb begin
		if (key_found_q) begin
			chosen     = key_addr_q;
			chosen_how = lst_pkg::HOW_KEY;
		end else if (exp_found_q) begin
			chosen     = exp_addr_q;
			chosen_how = lst_pkg::HOW_EXPIRED;
		end else begin
			chosen     = '0;
			chosen_how = lst_pkg::HOW_EVICT;
		end
	end

	assign chosen_ext = CHOSEN_EXT_W'(chosen);

	// Memory write: allocation load, or decay write-back from the unit
	always_comb begin
		mem_wr = unit_wr;
		if (alloc_wr) begin
			mem_wr.en    = 1'b1;
			mem_wr.addr  = chosen;
			mem_wr.entry = new_entry_q;
		end
	end

	lst_slot_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	lst_slot_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (cnt_q),
		.entry   (rd_data),
		.cmd     (cmd_q),
		.key     (key_q),
		.now     (now_q),
		.elapsed (elapsed_q),
		.hit     (hit),
		.wr      (unit_wr)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (cmd_q == lst_pkg::CMD_TICK) begin
				out_idx_q <= '0;
				out_how_q <= lst_pkg::HOW_TICK;
			end else begin
				out_idx_q <= chosen_ext[lst_pkg::IDX_W-1:0];
				out_how_q <= chosen_how;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_idx_q};
	assign m_tuser  = out_how_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lst_checker.sv
// Port-level checks of the light slot table, bound to the top level.
`default_nettype none

module lst_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [7:0]   m_tdata,
	input wire logic [1:0]   m_tuser
);

	// A waiting result holds until transferred
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// One item at a time: no transfer in the cycle after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// A tick result reports slot zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == lst_pkg::HOW_TICK) |-> m_tdata == 8'd0)
		else $error("tick result with nonzero slot");

	// No result can appear right after an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

bind light_slot_table_core lst_checker u_lst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
